### src/whp_pkg.sv
`timescale 1ns / 1ps

package whp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [15:0] PCM_FORMAT   = 16'd1;
    localparam logic [15:0] PCM_BITS     = 16'd16;

    localparam logic [1:0] KIND_HDR_OK = 2'd0;
    localparam logic [1:0] KIND_HDR_ERR = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_TAG   = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED = 3'd2;
    localparam logic [2:0] ERR_FORMAT    = 3'd3;
    localparam logic [2:0] ERR_NO_FMT    = 3'd4;

    typedef enum logic [8:0] {
        PH_RIFF  = 9'b0_0000_0001,
        PH_RSIZE = 9'b0_0000_0010,
        PH_WAVE  = 9'b0_0000_0100,
        PH_HDR   = 9'b0_0000_1000,
        PH_FMT   = 9'b0_0001_0000,
        PH_SKIP  = 9'b0_0010_0000,
        PH_PAD   = 9'b0_0100_0000,
        PH_PAY   = 9'b0_1000_0000,
        PH_DONE  = 9'b1_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [15:0]  sample;
        logic                channel;
        logic [31:0]         sample_rate;
        logic [1:0]          channel_total;
        logic [30:0]         total_frames;
        logic [2:0]          error_code;
    } t_result;

endpackage

### src/whp_in_reg.sv
`timescale 1ns / 1ps

module whp_in_reg
    import whp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic [7:0] i_data_byte,
    input  logic     i_last_byte,
    output logic     o_stall,
    input  logic     i_take,
    output logic     o_item_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_stall      = r_valid && !i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item.data_byte <= i_data_byte;
            r_item.last_byte <= i_last_byte;
        end
    end

endmodule

### src/whp_parser.sv
`timescale 1ns / 1ps

module whp_parser
    import whp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_in_item    i_item,
    output logic        o_take,
    input  logic [31:0] i_start_frame,
    input  logic        i_stall,
    output logic        o_valid,
    output t_result     o_result
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_fc, n_fc;
    logic [31:0] r_asm, n_asm;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [15:0] r_fmt, n_fmt;
    logic [1:0]  r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic        r_seen, n_seen;
    logic [7:0]  r_low, n_low;
    logic        r_ci, n_ci;
    logic [30:0] r_fdone, n_fdone;
    logic [30:0] r_ftot, n_ftot;

    logic        r_out_valid;
    t_result     r_out;
    logic        n_res_valid;
    t_result     n_res;

    assign o_take   = i_item_valid && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        logic [7:0]  b;
        logic [31:0] fc_inc;
        logic [15:0] v;
        logic        skip_req;
        logic [31:0] skip_cnt;
        logic [31:0] fin_len;
        logic [30:0] frames;
        logic        drop;

        b        = i_item.data_byte;
        fc_inc   = r_fc + 32'd1;
        skip_req = 1'b0;
        skip_cnt = '0;
        fin_len  = r_len;
        frames   = '0;
        drop     = 1'b0;

        n_phase = r_phase;
        n_fc    = r_fc;
        n_asm   = r_asm;
        n_tag   = r_tag;
        n_len   = r_len;
        n_fmt   = r_fmt;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_bits  = r_bits;
        n_seen  = r_seen;
        n_low   = r_low;
        n_ci    = r_ci;
        n_fdone = r_fdone;
        n_ftot  = r_ftot;
        n_res_valid = 1'b0;
        n_res       = '0;

        if (r_phase == PH_RIFF || r_phase == PH_RSIZE || r_phase == PH_WAVE ||
            r_phase == PH_HDR || r_phase == PH_FMT) begin
            n_asm = {b, r_asm[31:8]};
        end
        v = n_asm[31:16];

        case (r_phase)
            PH_RIFF, PH_RSIZE, PH_WAVE: begin
                n_fc = fc_inc;
                if (fc_inc == 32'd4) begin
                    n_fc = '0;
                    if ((r_phase == PH_RIFF && n_asm != TAG_RIFF) ||
                        (r_phase == PH_WAVE && n_asm != TAG_WAVE)) begin
                        n_res_valid      = 1'b1;
                        n_res.kind       = KIND_HDR_ERR;
                        n_res.error_code = ERR_BAD_TAG;
                        n_phase          = PH_DONE;
                    end else if (r_phase == PH_RIFF) begin
                        n_phase = PH_RSIZE;
                    end else if (r_phase == PH_RSIZE) begin
                        n_phase = PH_WAVE;
                    end else begin
                        n_phase = PH_HDR;
                    end
                end
            end
            PH_HDR: begin
                n_fc = fc_inc;
                if (fc_inc == 32'd4) begin
                    n_tag = n_asm;
                end else if (fc_inc == 32'd8) begin
                    n_len = n_asm;
                    n_fc  = '0;
                    if (r_tag == TAG_DATA) begin
                        n_res_valid = 1'b1;
                        if (!r_seen) begin
                            n_res.kind       = KIND_HDR_ERR;
                            n_res.error_code = ERR_NO_FMT;
                            n_phase          = PH_DONE;
                        end else if (r_fmt != PCM_FORMAT || r_bits != PCM_BITS ||
                                     r_chan == 2'd0 || r_chan == 2'd3) begin
                            n_res.kind       = KIND_HDR_ERR;
                            n_res.error_code = ERR_FORMAT;
                            n_phase          = PH_DONE;
                        end else begin
                            frames = (r_chan == 2'd2) ? {1'b0, n_asm[31:2]} : n_asm[31:1];
                            n_ftot  = frames;
                            n_fdone = '0;
                            n_ci    = 1'b0;
                            n_phase = (frames == '0) ? PH_DONE : PH_PAY;
                            n_res.kind          = KIND_HDR_OK;
                            n_res.sample_rate   = r_rate;
                            n_res.channel_total = r_chan;
                            n_res.total_frames  = frames;
                        end
                    end else if (r_tag == TAG_FMT) begin
                        n_phase = PH_FMT;
                    end else begin
                        skip_req = 1'b1;
                        skip_cnt = n_asm;
                        fin_len  = n_asm;
                    end
                end
            end
            PH_FMT: begin
                n_fc = fc_inc;
                if (fc_inc == 32'd2) begin
                    n_fmt = v;
                end else if (fc_inc == 32'd4) begin
                    n_chan = (v > 16'd2) ? 2'd3 : v[1:0];
                end else if (fc_inc == 32'd8) begin
                    n_rate = n_asm;
                end else if (fc_inc == FMT_BODY_LEN) begin
                    n_bits   = v;
                    n_seen   = 1'b1;
                    skip_req = 1'b1;
                    skip_cnt = (r_len > FMT_BODY_LEN) ? r_len - FMT_BODY_LEN : '0;
                end
            end
            PH_SKIP: begin
                n_fc = r_fc - 32'd1;
                if (n_fc == '0) begin
                    n_phase = r_len[0] ? PH_PAD : PH_HDR;
                end
            end
            PH_PAD: begin
                n_phase = PH_HDR;
                n_fc    = '0;
            end
            PH_PAY: begin
                if (r_fc == '0) begin
                    n_low = b;
                    n_fc  = 32'd1;
                end else begin
                    n_fc = '0;
                    drop = (i_start_frame <= {1'b0, r_ftot}) &&
                           ({1'b0, r_fdone} < i_start_frame);
                    if (!drop) begin
                        n_res_valid   = 1'b1;
                        n_res.kind    = KIND_SAMPLE;
                        n_res.sample  = {b, r_low};
                        n_res.channel = r_ci;
                    end
                    if (r_chan != 2'd2 || r_ci) begin
                        n_ci    = 1'b0;
                        n_fdone = r_fdone + 31'd1;
                        if (n_fdone >= r_ftot) begin
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_ci = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // chunk end: skip the rest, then pad byte on odd length
        if (skip_req) begin
            if (skip_cnt == '0) begin
                n_phase = fin_len[0] ? PH_PAD : PH_HDR;
                n_fc    = '0;
            end else begin
                n_phase = PH_SKIP;
                n_fc    = skip_cnt;
            end
        end

        if (i_item.last_byte) begin
            if (!n_res_valid && n_phase != PH_PAY && n_phase != PH_DONE) begin
                n_res_valid      = 1'b1;
                n_res            = '0;
                n_res.kind       = KIND_HDR_ERR;
                n_res.error_code = ERR_TRUNCATED;
            end
            n_phase = PH_RIFF;
            n_fc    = '0;
            n_asm   = '0;
            n_tag   = '0;
            n_len   = '0;
            n_fmt   = '0;
            n_chan  = '0;
            n_rate  = '0;
            n_bits  = '0;
            n_seen  = 1'b0;
            n_low   = '0;
            n_ci    = 1'b0;
            n_fdone = '0;
            n_ftot  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_fc        <= '0;
            r_asm       <= '0;
            r_tag       <= '0;
            r_len       <= '0;
            r_fmt       <= '0;
            r_chan      <= '0;
            r_rate      <= '0;
            r_bits      <= '0;
            r_seen      <= 1'b0;
            r_low       <= '0;
            r_ci        <= 1'b0;
            r_fdone     <= '0;
            r_ftot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase     <= n_phase;
                r_fc        <= n_fc;
                r_asm       <= n_asm;
                r_tag       <= n_tag;
                r_len       <= n_len;
                r_fmt       <= n_fmt;
                r_chan      <= n_chan;
                r_rate      <= n_rate;
                r_bits      <= n_bits;
                r_seen      <= n_seen;
                r_low       <= n_low;
                r_ci        <= n_ci;
                r_fdone     <= n_fdone;
                r_ftot      <= n_ftot;
                r_out_valid <= n_res_valid;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_res;
        end
    end

`ifndef ASSERT_OFF
    a_pay_needs_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAY |-> r_seen)
        else $error("payload phase without fmt chunk");

    a_pay_frames_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAY |-> r_fdone < r_ftot)
        else $error("payload phase past frame total");

    a_hdr_ok_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_HDR_OK |->
            r_out.channel_total == 2'd1 || r_out.channel_total == 2'd2)
        else $error("header accepted with bad channel count");

    a_err_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_HDR_ERR |-> r_out.error_code != ERR_NONE)
        else $error("header error without code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");
`endif

endmodule

### src/wav_header_parse_pcm16_stream.sv
`timescale 1ns / 1ps
// a byte passes the input register and then the result register; an output stall can hold it between them
// throughput: one byte per cycle, limited only by the output stall
// an input register and a result register, with the parse logic between them
// reset: synchronous active-low i_rst_n clears parser state, valids and start_frame
// a final byte returns the parser to its reset state, start_frame is kept

module wav_header_parse_pcm16_stream
    import whp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_sample,
    output logic               o_channel,
    output logic [31:0]        o_sample_rate,
    output logic [1:0]         o_channel_total,
    output logic [30:0]        o_total_frames,
    output logic [2:0]         o_error_code,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data
);

    logic [31:0] r_start_frame;
    logic        item_valid;
    t_in_item    item;
    logic        take;
    t_result     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_frame <= '0;
        end else if (i_cfg_we) begin
            r_start_frame <= i_cfg_data;
        end
    end

    whp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_stall      (o_stall),
        .i_take       (take),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    whp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_take        (take),
        .i_start_frame (r_start_frame),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_result      (result)
    );

    assign o_kind          = result.kind;
    assign o_sample        = result.sample;
    assign o_channel       = result.channel;
    assign o_sample_rate   = result.sample_rate;
    assign o_channel_total = result.channel_total;
    assign o_total_frames  = result.total_frames;
    assign o_error_code    = result.error_code;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import whp_pkg::*;

    class wav_parse_scoreboard;
        logic [31:0] seek_frame;
        t_phase      ph;
        logic [31:0] cnt, shreg, tag, clen, rate, frm_done;
        logic [15:0] fmt_code, bits;
        logic [1:0]  nch;
        logic        fmt_ok, ch_idx;
        logic [7:0]  lo;
        logic [30:0] frm_total;
        t_result     parser_outputs[$];
        int          fails;

        function new();
            seek_frame = '0;
            fails = 0;
            clear_file();
        endfunction

        function void clear_file();
            ph = PH_RIFF;
            cnt = '0; shreg = '0; tag = '0; clen = '0; rate = '0; frm_done = '0;
            fmt_code = '0; bits = '0; nch = '0; fmt_ok = 1'b0; ch_idx = 1'b0;
            lo = '0; frm_total = '0;
        endfunction

        function void chunk_end();
            ph = clen[0] ? PH_PAD : PH_HDR;
            cnt = '0;
        endfunction

        function void skip_bytes(input logic [31:0] n);
            if (n == 0) begin
                chunk_end();
            end else begin
                ph = PH_SKIP;
                cnt = n;
            end
        endfunction

        function t_result header_error(input logic [2:0] code);
            t_result r;
            r = '0;
            r.kind = KIND_HDR_ERR;
            r.error_code = code;
            ph = PH_DONE;
            return r;
        endfunction

        function void take_byte(input logic [7:0] b, input logic last);
            t_result     r;
            bit          got;
            logic [15:0] v;
            r = '0;
            got = 1'b0;
            if (ph <= PH_FMT) shreg = {b, shreg[31:8]};
            case (ph)
                PH_RIFF, PH_RSIZE, PH_WAVE: begin
                    cnt++;
                    if (cnt == 4) begin
                        cnt = '0;
                        if ((ph == PH_RIFF && shreg != TAG_RIFF) ||
                            (ph == PH_WAVE && shreg != TAG_WAVE)) begin
                            r = header_error(ERR_BAD_TAG);
                            got = 1'b1;
                        end else begin
                            ph = t_phase'(ph << 1);
                        end
                    end
                end
                PH_HDR: begin
                    cnt++;
                    if (cnt == 4) begin
                        tag = shreg;
                    end else if (cnt == 8) begin
                        clen = shreg;
                        cnt = '0;
                        if (tag == TAG_DATA) begin
                            got = 1'b1;
                            if (!fmt_ok) begin
                                r = header_error(ERR_NO_FMT);
                            end else if (fmt_code != PCM_FORMAT || bits != PCM_BITS ||
                                         nch == 0 || nch > 2) begin
                                r = header_error(ERR_FORMAT);
                            end else begin
                                frm_total = 31'(clen / (32'd2 * nch));
                                frm_done = '0;
                                ch_idx = 1'b0;
                                ph = (frm_total == 0) ? PH_DONE : PH_PAY;
                                r.kind = KIND_HDR_OK;
                                r.sample_rate = rate;
                                r.channel_total = nch;
                                r.total_frames = frm_total;
                            end
                        end else if (tag == TAG_FMT) begin
                            ph = PH_FMT;
                        end else begin
                            skip_bytes(clen);
                        end
                    end
                end
                PH_FMT: begin
                    cnt++;
                    v = shreg[31:16];
                    if (cnt == 2) begin
                        fmt_code = v;
                    end else if (cnt == 4) begin
                        nch = (v > 2) ? 2'd3 : v[1:0];
                    end else if (cnt == 8) begin
                        rate = shreg;
                    end else if (cnt == FMT_BODY_LEN) begin
                        bits = v;
                        fmt_ok = 1'b1;
                        skip_bytes(clen > FMT_BODY_LEN ? clen - FMT_BODY_LEN : 32'd0);
                    end
                end
                PH_SKIP: begin
                    cnt--;
                    if (cnt == 0) chunk_end();
                end
                PH_PAD: begin
                    ph = PH_HDR;
                    cnt = '0;
                end
                PH_PAY: begin
                    if (cnt == 0) begin
                        lo = b;
                        cnt = 1;
                    end else begin
                        cnt = '0;
                        // seek applies only when it lies inside the payload
                        if (!(seek_frame <= {1'b0, frm_total} && frm_done < seek_frame)) begin
                            got = 1'b1;
                            r.kind = KIND_SAMPLE;
                            r.sample = {b, lo};
                            r.channel = ch_idx;
                        end
                        if (int'(ch_idx) + 1 >= int'(nch)) begin
                            ch_idx = 1'b0;
                            frm_done++;
                            if (frm_done >= {1'b0, frm_total}) ph = PH_DONE;
                        end else begin
                            ch_idx = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (last) begin
                if (!got && ph < PH_PAY) begin
                    r = header_error(ERR_TRUNCATED);
                    got = 1'b1;
                end
                clear_file();
            end
            if (got) parser_outputs.push_back(r);
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                fails++;
            end
        endfunction

        function void check_output(input t_result act);
            t_result want;
            if (parser_outputs.size() == 0) begin
                $error("result item with none pending: kind %0d", act.kind);
                fails++;
                return;
            end
            want = parser_outputs.pop_front();
            check_field("kind", 32'(want.kind), 32'(act.kind));
            check_field("sample", 32'(unsigned'(want.sample)), 32'(unsigned'(act.sample)));
            check_field("channel", 32'(want.channel), 32'(act.channel));
            check_field("sample_rate", want.sample_rate, act.sample_rate);
            check_field("channel_total", 32'(want.channel_total), 32'(act.channel_total));
            check_field("total_frames", 32'(want.total_frames), 32'(act.total_frames));
            check_field("error_code", 32'(want.error_code), 32'(act.error_code));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_data_byte = '0;
    logic               i_last_byte = 1'b0;
    logic               i_stall = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [31:0]        i_cfg_data = '0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_kind;
    logic signed [15:0] o_sample;
    logic               o_channel;
    logic [31:0]        o_sample_rate;
    logic [1:0]         o_channel_total;
    logic [30:0]        o_total_frames;
    logic [2:0]         o_error_code;

    wav_parse_scoreboard sb;
    logic [7:0]          file_bytes[$];
    bit                  tx_burst = 1'b0;
    bit                  rx_burst = 1'b0;
    bit                  hold_off_req = 1'b0;
    logic [31:0]         seek_plan[7] = '{32'd0, 32'hFFFF_FFFF, 32'd2, 32'd0, 32'd1,
                                          32'd5, 32'd0};

    wav_header_parse_pcm16_stream uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_sample        (o_sample),
        .o_channel       (o_channel),
        .o_sample_rate   (o_sample_rate),
        .o_channel_total (o_channel_total),
        .o_total_frames  (o_total_frames),
        .o_error_code    (o_error_code),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void emit_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void emit_fmt();
        int          len;
        logic [15:0] chans, fcode, bps;
        case ($urandom_range(0, 5))
            3:       len = 18;
            4:       len = $urandom_range(12, 15);
            5:       len = $urandom_range(17, 21);
            default: len = 16;
        endcase
        fcode = ($urandom_range(0, 9) == 0) ? 16'($urandom) : PCM_FORMAT;
        bps = ($urandom_range(0, 9) == 0) ? 16'($urandom) : PCM_BITS;
        case ($urandom_range(0, 9))
            8:       chans = 16'd0;
            9:       chans = 16'($urandom_range(3, 65535));
            default: chans = 16'($urandom_range(1, 2));
        endcase
        emit_le(TAG_FMT, 4);
        emit_le(len, 4);
        emit_le(32'(fcode), 2);
        emit_le(32'(chans), 2);
        emit_le($urandom, 4);
        emit_le($urandom, 4);
        emit_le($urandom, 2);
        emit_le(32'(bps), 2);
        for (int i = 16; i < len; i++) file_bytes.push_back(8'($urandom));
        if (len % 2 == 1) file_bytes.push_back(8'($urandom));
    endfunction

    // most files are well formed; the rest lack fmt, carry a bad tag or end early
    function automatic void build_file();
        int          style, sz, dsize, plen, keep, k;
        file_bytes.delete();
        style = $urandom_range(0, 19);
        emit_le(TAG_RIFF, 4);
        emit_le($urandom, 4);
        emit_le(TAG_WAVE, 4);
        if (style == 16 || style == 17) begin
            k = (style == 16) ? $urandom_range(0, 3) : $urandom_range(8, 11);
            file_bytes[k] = file_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
        end
        repeat ($urandom_range(0, 2)) begin
            sz = $urandom_range(0, 7);
            emit_le($urandom, 4);
            emit_le(sz, 4);
            repeat (sz + sz % 2) file_bytes.push_back(8'($urandom));
        end
        if (style != 14 && style != 15) begin
            repeat (($urandom_range(0, 5) == 0) ? 2 : 1) emit_fmt();
        end
        dsize = ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(0, 24);
        emit_le(TAG_DATA, 4);
        emit_le(dsize, 4);
        if (dsize < 0 || dsize > 24) begin
            plen = $urandom_range(0, 24);
        end else if ($urandom_range(0, 3) == 0) begin
            plen = $urandom_range(0, dsize);
        end else begin
            plen = dsize + $urandom_range(0, 3);
        end
        repeat (plen) file_bytes.push_back(8'($urandom));
        if (style >= 16) begin
            if (style >= 18) keep = $urandom_range(1, file_bytes.size() - 1);
            else keep = $urandom_range((style == 16) ? 4 : 12, 20);
            file_bytes = file_bytes[0:keep-1];
        end
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_byte(b, l);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            put_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.parser_outputs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_seek(input logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.seek_frame = v;
    endtask

    initial begin : result_sink
        int wait_n;
        wait_n = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                sb.check_output(t_result'({o_kind, o_sample, o_channel, o_sample_rate,
                                           o_channel_total, o_total_frames, o_error_code}));
                wait_n = rx_burst ? 0 : $urandom_range(0, 8);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                wait_n = 300;
            end
            if (wait_n > 0) begin
                i_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
                i_stall <= 1'b0;
                wait_n = 0;
            end
        end
    end

    initial begin
        int sent;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_seek(32'd0);

        // bad riff tag, bad wave tag, early ends
        file_bytes = '{8'h52, 8'h49, 8'h46, 8'h58};
        send_file();
        file_bytes.delete();
        emit_le(TAG_RIFF, 4);
        emit_le(32'hFFFF_FFFF, 4);
        emit_le(TAG_WAVE ^ 32'h8000_0000, 4);
        send_file();
        file_bytes = '{8'h00, 8'hFF, 8'h80};
        send_file();
        file_bytes = '{8'hAA};
        send_file();

        seek_plan[4] = $urandom_range(1, 6);
        for (int p = 0; p < 7; p++) begin
            settle();
            write_seek(seek_plan[p]);
            sent = 0;
            while (sent < 190) begin
                build_file();
                tx_burst = ($urandom_range(0, 4) == 0);
                rx_burst = ($urandom_range(0, 4) == 0);
                if (p == 3 && sent == 0) begin
                    tx_burst = 1'b1;
                    hold_off_req = 1'b1;
                end
                send_file();
                sent += file_bytes.size();
                if ($urandom_range(0, 9) == 0) settle();
            end
        end
        settle();
        if (sb.fails == 0 && sb.parser_outputs.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
src/whp_pkg.sv
src/whp_in_reg.sv
src/whp_parser.sv
src/wav_header_parse_pcm16_stream.sv
verif/tb_top.sv
